/* hw/rtl/cfla_pkg.sv */
// ----------------------------------------------------------------------------
// cfla_pkg
// Types and constants shared by the frequency-limit aggregator.
// ----------------------------------------------------------------------------
package cfla_pkg;

    localparam int unsigned FW = 22;
    localparam logic [FW-1:0] FREQ_MAX = 22'h3FFFFF;

    typedef logic [FW-1:0] freq_t;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_EVAL   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_RANGE = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_HANDLE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BOOST_NONE    = 2'd0,
        BOOST_ENABLE  = 2'd1,
        BOOST_DISABLE = 2'd2
    } boost_t;

    typedef enum logic [2:0] {
        REG_LFIRST  = 3'd0,
        REG_LLAST   = 3'd1,
        REG_THRESH  = 3'd2,
        REG_FLOOR   = 3'd3,
        REG_LOCK    = 3'd4,
        REG_RATIO   = 3'd5,
        REG_BMODE   = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_LAST,
        S_FILL,
        S_DIV,
        S_MAP,
        S_MUL,
        S_REMOVE_RD,
        S_REMOVE_WB,
        S_DONE
    } state_t;

endpackage

/* hw/rtl/cfla_ram.sv */
// ----------------------------------------------------------------------------
// cfla_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/cfla_div.sv */
// ----------------------------------------------------------------------------
// cfla_div
// Restoring divider, one quotient bit per cycle, 22-bit by 4-bit.
// ----------------------------------------------------------------------------
module cfla_div
    import cfla_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  freq_t      dividend,
    input  logic [3:0] divisor,
    output logic       done,
    output freq_t      quotient
);

    localparam int CW = $clog2(FW + 1);

    freq_t         q_reg, q_next;
    logic [4:0]    r_reg, r_next;
    logic [3:0]    d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [4:0]    trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {r_reg[3:0], q_reg[FW-1]};
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
            cnt_next = CW'(FW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[FW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[FW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* hw/rtl/cpu_freq_limit_aggregator.sv */
// ----------------------------------------------------------------------------
// cpu_freq_limit_aggregator
// Frequency-limit request table with cluster mapping and boost control.
// ----------------------------------------------------------------------------
// Add: free-slot search over the used bits. Remove: read the slot, then clear its used bit.
// Evaluate: one slot read per cycle from the min/max RAMs, then a bit-serial
// divide for little cores when one of the min and max requests is unset.
// One command at a time; busy is high through the result strobe.
// The receiver cannot stall; done is high for a single cycle and the result words hold until the next accept.
// Reset clears used bits and boost state and loads config defaults; RAM contents are not reset.
module cpu_freq_limit_aggregator
    import cfla_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [21:0] cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [3:0]  handle_in,
    input  logic [21:0] req_min,
    input  logic [21:0] req_max,
    input  logic        release_req,
    input  logic [3:0]  cpu_index,
    input  logic [21:0] cpu_min_freq,
    input  logic [21:0] cpu_max_freq,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  handle_out,
    output logic [21:0] limit_min,
    output logic [21:0] limit_max,
    output logic        limit_applied,
    output logic [1:0]  boost_action,
    output logic        load_alert,
    output logic        reevaluate
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // configuration
    logic [3:0] lfirst_reg, llast_reg, ratio_reg;
    freq_t      thresh_reg, floor_reg, lock_reg;
    logic [1:0] bmode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfirst_reg <= 4'd0;
            llast_reg  <= 4'd3;
            thresh_reg <= 22'd883200;
            floor_reg  <= 22'd883200;
            lock_reg   <= 22'd403200;
            ratio_reg  <= 4'd2;
            bmode_reg  <= 2'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LFIRST: lfirst_reg <= cfg_wdata[3:0];
                REG_LLAST:  llast_reg  <= cfg_wdata[3:0];
                REG_THRESH: thresh_reg <= cfg_wdata;
                REG_FLOOR:  floor_reg  <= cfg_wdata;
                REG_LOCK:   lock_reg   <= cfg_wdata;
                REG_RATIO:  ratio_reg  <= cfg_wdata[3:0];
                REG_BMODE:  bmode_reg  <= cfg_wdata[1:0];
                default:    ;
            endcase
        end
    end

    logic [3:0] ratio_eff;
    assign ratio_eff = (ratio_reg == 4'd0) ? 4'd1 : ratio_reg;

    // storage
    logic [SLOTS-1:0] used_reg, used_next;
    logic             boost_reg, boost_next;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    freq_t            min_rd, max_rd;

    cfla_ram #(.WIDTH(FW), .DEPTH(SLOTS)) u_min_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(req_min),
        .raddr(ram_raddr), .rdata(min_rd)
    );
    cfla_ram #(.WIDTH(FW), .DEPTH(SLOTS)) u_max_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(req_max),
        .raddr(ram_raddr), .rdata(max_rd)
    );

    // latched command
    state_t     state_reg, state_next;
    logic       accept;
    logic [3:0] hin_reg;
    logic       rel_reg;
    freq_t      hwmin_reg, hwmax_reg;
    logic [AW-1:0] free_idx;
    logic          free_found;

    assign accept = start && !busy;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    // remove handle decode
    logic [3:0]    hin_sel;
    logic [AW-1:0] hin_idx;
    logic          hin_ok;
    logic [AW-1:0] ram_raddr_q;
    assign hin_sel = (state_reg == S_IDLE) ? handle_in : hin_reg;
    assign hin_idx = AW'(hin_sel);
    assign hin_ok  = ({28'd0, hin_reg} < 32'(SLOTS));

    // scan and evaluate datapath
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] rd_idx_reg;
    logic          rd_valid_reg;
    freq_t lo_reg, lo_next, hi_reg, hi_next;
    logic  has_hi_reg, has_hi_next;
    logic  little_reg, little_next;
    logic  div_sel_reg, div_sel_next;
    logic  div_start;
    freq_t div_in, div_q;
    logic  div_done;
    logic  boost_en_reg, boost_en_next;
    freq_t mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;

    cfla_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_in),
        .divisor(ratio_eff), .done(div_done), .quotient(div_q)
    );

    // result
    logic       done_reg, done_next;
    logic [1:0] status_reg, status_next, boost_act_reg, boost_act_next;
    logic [3:0] hout_reg, hout_next;
    freq_t      lmin_reg, lmin_next, lmax_reg, lmax_next;
    logic       lapp_reg, lapp_next, alert_reg, alert_next, reev_reg, reev_next;
    logic [FW+3:0] prod_a, prod_b;
    logic  ld_used;

    assign prod_a = mul_a_reg * ratio_eff;
    assign prod_b = mul_b_reg * ratio_eff;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_EVAL:   state_next = S_SCAN;
                        CMD_REMOVE: state_next = S_REMOVE_RD;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:      state_next = (cnt_reg == CW'(1)) ? S_SCAN_LAST : S_SCAN;
            S_SCAN_LAST: state_next = S_FILL;
            S_FILL:
            begin
                if (lo_reg == '0 && !has_hi_reg)
                    state_next = S_DONE;
                else if (little_reg && (lo_reg == '0 || !has_hi_reg))
                    state_next = S_DIV;
                else
                    state_next = S_MAP;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = (div_sel_reg || lo_reg != '0 || has_hi_reg) ? S_MAP : S_DIV;
            end
            S_MAP:       state_next = little_reg ? S_MUL : S_DONE;
            S_MUL:       state_next = S_DONE;
            S_REMOVE_RD: state_next = S_REMOVE_WB;
            S_REMOVE_WB: state_next = S_DONE;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        has_hi_next   = has_hi_reg;
        little_next   = little_reg;
        div_sel_next  = div_sel_reg;
        boost_en_next = boost_en_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        used_next     = used_reg;
        boost_next    = boost_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        hout_next     = hout_reg;
        lmin_next     = lmin_reg;
        lmax_next     = lmax_reg;
        lapp_next     = lapp_reg;
        boost_act_next = boost_act_reg;
        alert_next    = alert_reg;
        reev_next     = reev_reg;
        ram_we        = 1'b0;
        ram_waddr     = free_idx;
        ram_raddr     = rd_idx_reg;
        div_start     = 1'b0;
        div_in        = hwmin_reg;
        ld_used       = rd_valid_reg && used_reg[ram_raddr_q];
        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = hin_idx;
                if (accept)
                begin
                    status_next = ST_OK; hout_next = '0; lmin_next = '0;
                    lmax_next = '0; lapp_next = 1'b0; boost_act_next = BOOST_NONE;
                    alert_next = 1'b0; reev_next = 1'b0;
                    cnt_next = CW'(SLOTS);
                    lo_next = '0; hi_next = '0; has_hi_next = 1'b0;
                    little_next = (cpu_index >= lfirst_reg) && (cpu_index <= llast_reg);
                    if (command == CMD_ADD)
                    begin
                        if (req_max != '0 && req_max < req_min)
                            status_next = ST_BAD_RANGE;
                        else if (!free_found)
                            status_next = ST_FULL;
                        else
                        begin
                            ram_we = 1'b1;
                            used_next[free_idx] = 1'b1;
                            hout_next = 4'(free_idx);
                            reev_next = 1'b1;
                        end
                    end
                end
            end
            S_SCAN, S_SCAN_LAST:
            begin
                if (state_reg == S_SCAN)
                    cnt_next = cnt_reg - 1'b1;
                if (ld_used)
                begin
                    if (min_rd > lo_reg)
                        lo_next = min_rd;
                    if (max_rd != '0 && (!has_hi_reg || max_rd < hi_reg))
                    begin
                        hi_next = max_rd;
                        has_hi_next = 1'b1;
                    end
                end
            end
            S_FILL:
            begin
                if (lo_reg == '0 && !has_hi_reg)
                begin
                    if (bmode_reg != 2'd0 && boost_reg)
                    begin
                        boost_next = 1'b0;
                        boost_act_next = BOOST_DISABLE;
                    end
                end
                else if (little_reg && lo_reg == '0)
                begin
                    div_start = 1'b1; div_in = hwmin_reg; div_sel_next = 1'b0;
                end
                else if (little_reg && !has_hi_reg)
                begin
                    div_start = 1'b1; div_in = hwmax_reg; div_sel_next = 1'b1;
                end
                else
                begin
                    if (lo_reg == '0) lo_next = hwmin_reg;
                    if (!has_hi_reg) hi_next = hwmax_reg;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (!div_sel_reg)
                    begin
                        lo_next = div_q;
                        if (!has_hi_reg)
                        begin
                            div_start = 1'b1; div_in = hwmax_reg; div_sel_next = 1'b1;
                            has_hi_next = 1'b0;
                        end
                    end
                    else
                    begin
                        hi_next = div_q;
                        has_hi_next = 1'b1;
                    end
                end
            end
            S_MAP:
            begin
                lapp_next = 1'b1;
                if (little_reg)
                begin
                    mul_a_next = (lo_reg >= thresh_reg) ? lock_reg : lo_reg;
                    mul_b_next = hi_reg;
                end
                else
                begin
                    boost_en_next = 1'b1;
                    lmin_next = lo_reg; lmax_next = hi_reg;
                    if (lo_reg < thresh_reg)
                    begin
                        lmin_next = floor_reg; boost_en_next = 1'b0;
                    end
                    if (hi_reg < thresh_reg)
                    begin
                        lmax_next = floor_reg; boost_en_next = 1'b0;
                    end
                    if (bmode_reg != 2'd0)
                    begin
                        if (boost_en_next && !boost_reg)
                        begin
                            boost_next = 1'b1; boost_act_next = BOOST_ENABLE;
                        end
                        else if (!boost_en_next && boost_reg)
                        begin
                            boost_next = 1'b0; boost_act_next = BOOST_DISABLE;
                        end
                    end
                end
            end
            S_MUL:
            begin
                lmin_next = (prod_a > {4'd0, FREQ_MAX}) ? FREQ_MAX : prod_a[FW-1:0];
                if (mul_b_reg >= thresh_reg)
                    lmax_next = hwmax_reg;
                else
                    lmax_next = (prod_b > {4'd0, FREQ_MAX}) ? FREQ_MAX : prod_b[FW-1:0];
            end
            S_REMOVE_RD:
            begin
                ram_raddr = hin_idx;
            end
            S_REMOVE_WB:
            begin
                if (!hin_ok || !used_reg[hin_idx])
                    status_next = ST_NO_HANDLE;
                else
                begin
                    used_next[hin_idx] = 1'b0;
                    alert_next = rel_reg && (min_rd != '0);
                    reev_next = 1'b1;
                end
            end
            S_DONE:
            begin
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            boost_reg    <= 1'b0;
            done_reg     <= 1'b0;
            cnt_reg      <= '0;
            rd_idx_reg   <= '0;
            rd_valid_reg <= 1'b0;
            ram_raddr_q  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            boost_reg    <= boost_next;
            done_reg     <= done_next;
            cnt_reg      <= cnt_next;
            ram_raddr_q  <= ram_raddr;
            rd_valid_reg <= (state_reg == S_SCAN);
            if (state_reg == S_IDLE)
                rd_idx_reg <= '0;
            else if (state_reg == S_SCAN)
                rd_idx_reg <= rd_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            hin_reg   <= handle_in;
            rel_reg   <= release_req;
            hwmin_reg <= cpu_min_freq;
            hwmax_reg <= cpu_max_freq;
        end
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        has_hi_reg    <= has_hi_next;
        little_reg    <= little_next;
        div_sel_reg   <= div_sel_next;
        boost_en_reg  <= boost_en_next;
        mul_a_reg     <= mul_a_next;
        mul_b_reg     <= mul_b_next;
        status_reg    <= status_next;
        hout_reg      <= hout_next;
        lmin_reg      <= lmin_next;
        lmax_reg      <= lmax_next;
        lapp_reg      <= lapp_next;
        boost_act_reg <= boost_act_next;
        alert_reg     <= alert_next;
        reev_reg      <= reev_next;
    end

    assign busy          = (state_reg != S_IDLE) || done_reg;
    assign done          = done_reg;
    assign status        = status_reg;
    assign handle_out    = hout_reg;
    assign limit_min     = lmin_reg;
    assign limit_max     = lmax_reg;
    assign limit_applied = lapp_reg;
    assign boost_action  = boost_act_reg;
    assign load_alert    = alert_reg;
    assign reevaluate    = reev_reg;

endmodule
